FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HPT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HPT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform core.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int HPT_DATA_WIDTH  = 32;
    localparam int HPT_FRAC_BITS   = 16;
    localparam int HPT_QUEUE_DEPTH = 4;
    localparam int HPT_INDEX_BITS  = 4;
    localparam int HPT_ELEMENTS    = 16;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } opcode_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: rtl/core/hpt_queue.sv
// ----------------------------------------------------------------------------
// hpt_queue
// Small register queue carrying transform requests from front to back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpt_queue
    import hpt_pkg::*;
#(
    parameter int WIDTH = 3 * HPT_DATA_WIDTH,
    parameter int DEPTH = HPT_QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `HPT_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count above depth")

endmodule

FILE: rtl/core/hpt_front.sv
// ----------------------------------------------------------------------------
// hpt_front
// Takes requests, applies matrix loads and queues transform requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpt_front
    import hpt_pkg::*;
#(
    parameter int DATA_WIDTH = HPT_DATA_WIDTH,
    parameter int FRAC_BITS  = HPT_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  opcode_t                       in_op,
    input  logic [HPT_INDEX_BITS-1:0]     in_index,
    input  logic [DATA_WIDTH-1:0]         in_value,
    input  logic [3*DATA_WIDTH-1:0]       in_point,
    input  queue_status_t                 q_status,
    output logic                          q_push,
    output logic [3*DATA_WIDTH-1:0]       q_data,
    output logic signed [DATA_WIDTH-1:0]  matrix [HPT_ELEMENTS]
);

    localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

    logic                          hold_valid_reg;
    opcode_t                       hold_op_reg;
    logic [HPT_INDEX_BITS-1:0]     hold_index_reg;
    logic [DATA_WIDTH-1:0]         hold_value_reg;
    logic [3*DATA_WIDTH-1:0]       hold_point_reg;
    logic signed [DATA_WIDTH-1:0]  matrix_reg [HPT_ELEMENTS];
    logic                          issue, load_issue;

    // A load waits for the queue to drain so queued points see the old matrix.
    assign q_push     = hold_valid_reg && (hold_op_reg == OP_XFORM) && !q_status.full;
    assign load_issue = hold_valid_reg && (hold_op_reg == OP_LOAD) && q_status.empty;
    assign issue      = q_push || load_issue;
    assign in_ready   = !hold_valid_reg || issue;
    assign q_data     = hold_point_reg;
    assign matrix     = matrix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_op_reg    <= in_op;
            hold_index_reg <= in_index;
            hold_value_reg <= in_value;
            hold_point_reg <= in_point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HPT_ELEMENTS; k++)
            begin
                matrix_reg[k] <= (k % 5 == 0) ? ONE : '0;
            end
        end
        else if (load_issue)
        begin
            matrix_reg[hold_index_reg] <= hold_value_reg;
        end
    end

    `HPT_ASSERT(a_load_on_empty, load_issue |-> q_status.empty && !q_push, "load while queue busy")

endmodule

FILE: rtl/core/hpt_back.sv
// ----------------------------------------------------------------------------
// hpt_back
// Matrix product, sum, and pipelined restoring divide by w.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpt_back
    import hpt_pkg::*;
#(
    parameter int DATA_WIDTH = HPT_DATA_WIDTH,
    parameter int FRAC_BITS  = HPT_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [DATA_WIDTH-1:0]  matrix [HPT_ELEMENTS],
    input  queue_status_t                 q_status,
    input  logic [3*DATA_WIDTH-1:0]       q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DATA_WIDTH-1:0]         out_x,
    output logic [DATA_WIDTH-1:0]         out_y,
    output logic [DATA_WIDTH-1:0]         out_z,
    output logic                          out_dbz,
    output logic                          out_sat
);

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 2;
    localparam int RW  = 3 * W + FRAC_BITS + 3;
    localparam int NST = W + 4;

    logic                   vld_reg [NST];
    logic                   en;

    logic signed [PW-1:0]   prod_reg [4][3];
    logic signed [W-1:0]    wterm_reg [4];
    logic signed [SW-1:0]   sum_reg [4];

    // divider pipe; index 0 is loaded from the sums
    logic [RW-1:0]          rem_reg  [W+1][3];
    logic [W-1:0]           quo_reg  [W+1][3];
    logic [RW-1:0]          den_reg  [W+1];
    logic                   rneg_reg [W+1][3];
    logic                   ovf_reg  [W+1][3];
    logic                   dbz_reg  [W+1];

    logic [W-1:0]           res_reg [3];
    logic                   dbz_out_reg, sat_out_reg;

    logic signed [W-1:0]    pt [3];

    assign pt[0] = q_data[W-1:0];
    assign pt[1] = q_data[2*W-1:W];
    assign pt[2] = q_data[3*W-1:2*W];

    // Stall the whole pipe while the finished result waits.
    assign en        = !(vld_reg[NST-1] && !out_ready);
    assign q_pop     = en && !q_status.empty;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !q_status.empty;
            for (int k = 1; k < NST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[j][i] <= matrix[4*i+j] * pt[i];
                end
                wterm_reg[j] <= matrix[12+j];
            end
        end
    end

    // sums; the implicit w of 1.0 adds the last row shifted up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                sum_reg[j] <= SW'(prod_reg[j][0]) + SW'(prod_reg[j][1])
                            + SW'(prod_reg[j][2]) + (SW'(wterm_reg[j]) <<< FRAC_BITS);
            end
        end
    end

    // magnitudes, sign of result, early overflow check
    always_ff @(posedge clk)
    begin
        logic [SW-1:0] dmag;
        logic [SW-1:0] nmag;
        logic [RW-1:0] dwide;
        logic [RW-1:0] nwide;
        if (en)
        begin
            dmag  = sum_reg[3][SW-1] ? SW'(-sum_reg[3]) : SW'(sum_reg[3]);
            dwide = RW'(dmag);
            den_reg[0] <= dwide;
            dbz_reg[0] <= (sum_reg[3] == '0);
            for (int j = 0; j < 3; j++)
            begin
                nmag  = sum_reg[j][SW-1] ? SW'(-sum_reg[j]) : SW'(sum_reg[j]);
                nwide = RW'(nmag) << FRAC_BITS;
                rem_reg[0][j]  <= nwide;
                quo_reg[0][j]  <= '0;
                rneg_reg[0][j] <= sum_reg[j][SW-1] != sum_reg[3][SW-1];
                ovf_reg[0][j]  <= nwide >= (dwide << W);
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < W; k++)
    begin : g_div
        localparam int BIT = W - 1 - k;
        always_ff @(posedge clk)
        begin
            logic [RW-1:0] dsh;
            if (en)
            begin
                dsh = den_reg[k] << BIT;
                den_reg[k+1] <= den_reg[k];
                dbz_reg[k+1] <= dbz_reg[k];
                for (int j = 0; j < 3; j++)
                begin
                    rneg_reg[k+1][j] <= rneg_reg[k][j];
                    ovf_reg[k+1][j]  <= ovf_reg[k][j];
                    if (rem_reg[k][j] >= dsh)
                    begin
                        rem_reg[k+1][j] <= rem_reg[k][j] - dsh;
                        quo_reg[k+1][j] <= quo_reg[k][j] | (W'(1) << BIT);
                    end
                    else
                    begin
                        rem_reg[k+1][j] <= rem_reg[k][j];
                        quo_reg[k+1][j] <= quo_reg[k][j];
                    end
                end
            end
        end
    end

    // clamp, apply sign, zero on divide by zero, output register
    always_ff @(posedge clk)
    begin
        logic [W-1:0] lim;
        logic [W-1:0] mag;
        logic         sat;
        if (en)
        begin
            sat = 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                lim = rneg_reg[W][j] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                mag = quo_reg[W][j];
                if (ovf_reg[W][j] || (quo_reg[W][j] > lim))
                begin
                    mag = lim;
                    sat = 1'b1;
                end
                res_reg[j] <= dbz_reg[W] ? '0 : (rneg_reg[W][j] ? -mag : mag);
            end
            dbz_out_reg <= dbz_reg[W];
            sat_out_reg <= sat && !dbz_reg[W];
        end
    end

    assign out_x   = res_reg[0];
    assign out_y   = res_reg[1];
    assign out_z   = res_reg[2];
    assign out_dbz = dbz_out_reg;
    assign out_sat = sat_out_reg;

    `HPT_ASSERT(a_dbz_no_sat, out_valid && out_dbz |-> !out_sat, "saturation with zero divisor")
    `HPT_ASSERT(a_dbz_zero, out_valid && out_dbz |-> (out_x | out_y | out_z) == '0, "nonzero on dbz")

endmodule

FILE: rtl/core/homogeneous_point_transform_core.sv
// Path: input register, queue, product, sum, magnitude, divider and output registers.
// Throughput: one per cycle unless m_tready stalls; the divider is one quotient bit per stage.
// A load waits in the input register until queued transforms have left the queue.
// Reset: matrix returns to identity, queue and pipeline empty; requests in flight are dropped.
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core
// 4x4 fixed-point point transform with perspective divide, stream interface.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_core
    import hpt_pkg::*;
#(
    parameter int DATA_WIDTH = HPT_DATA_WIDTH,
    parameter int FRAC_BITS  = HPT_FRAC_BITS
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // element_index, element_value, point_x, point_y, point_z
    input  logic [((HPT_INDEX_BITS+4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic                                     s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // out_x, out_y, out_z
    output logic [((3*DATA_WIDTH+7)/8)*8-1:0]        m_tdata,
    // divide_by_zero, saturated
    output logic [1:0]                               m_tuser
);

    localparam int W     = DATA_WIDTH;
    localparam int OUT_W = ((3*DATA_WIDTH+7)/8)*8;
    localparam int IB    = HPT_INDEX_BITS;

    queue_status_t                q_status;
    logic                         q_push, q_pop;
    logic [3*W-1:0]               q_wdata, q_rdata;
    logic signed [W-1:0]          matrix [HPT_ELEMENTS];
    logic [W-1:0]                 res_x, res_y, res_z;
    logic                         res_dbz, res_sat;

    hpt_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (opcode_t'(s_tuser)),
        .in_index (s_tdata[IB-1:0]),
        .in_value (s_tdata[IB+W-1:IB]),
        .in_point (s_tdata[IB+4*W-1:IB+W]),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .matrix   (matrix)
    );

    hpt_queue #(
        .WIDTH (3*W),
        .DEPTH (HPT_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .status    (q_status)
    );

    hpt_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .matrix    (matrix),
        .q_status  (q_status),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_z     (res_z),
        .out_dbz   (res_dbz),
        .out_sat   (res_sat)
    );

    assign m_tdata = OUT_W'({res_z, res_y, res_x});
    assign m_tuser = {res_sat, res_dbz};

endmodule
